// File: src/st1c_pkg.sv
package st1c_pkg;
    localparam int LOGIT_W = 16;
    localparam int CLASS_W = 6;
    localparam int CONF_W  = 16;
    localparam int NCLS_W  = 7;
    localparam int SUM_W   = 22;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [0:0] CFG_NUM_CLASSES = 1'b0;
    localparam logic [0:0] CFG_THRESHOLD   = 1'b1;
    localparam int CFG_IDX_W = 1;

    // 32768*exp(-k/16), Q1.15, same recurrence as the golden table
    function automatic logic [15:0] exp_entry(input int k);
        logic [63:0] p;
        logic [63:0] e;
        p = 64'd1 << 32;
        for (int j = 0; j < k; j++) begin
            p = (p * 64'hF07D5F5E + (64'd1 << 31)) >> 32;
        end
        e = (p + (64'd1 << 16)) >> 17;
        return e[15:0];
    endfunction
endpackage

// File: src/st1c_if.sv
interface st1c_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] logit;
    logic batch_end;
    modport source (output valid, logit, batch_end, input ready);
    modport sink (input valid, logit, batch_end, output ready);
endinterface

interface st1c_out_if;
    logic valid;
    logic ready;
    logic [5:0] class_index;
    logic [15:0] confidence;
    logic confident;
    logic batch_last;
    modport source (output valid, class_index, confidence, confident, batch_last, input ready);
    modport sink (input valid, class_index, confidence, confident, batch_last, output ready);
endinterface

interface st1c_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/softmax_top1_classifier.sv
// softmax_top1_classifier: top-1 class and softmax confidence per logit row.
// Channels: in (one logit word per accept, batch_end marks the batch's final
// logit), out (one result word per closed row), cfg (index 0 num_classes,
// index 1 conf_threshold; write only while idle).
// Logits land in a row memory with one write and one read port; the running
// max is tracked on the fly. Input accepts one word per cycle while a row fills.
// When a row of N closes, the block walks the memory, one read and one add per
// stored word, then runs a restoring divide of 2^31 by the sum: one setup step
// and 17 one-bit steps. The next row may start loading while the result waits,
// but a new row cannot close until the result is taken. No input is accepted
// while a row is walked and divided.
// Reset clears counters, best value and config to 16 / 32768; no memory
// clearing, only entries written in the current row are read.
// A stalled receiver holds the result word steady and backs up input at the
// closing logit of the following row.
module softmax_top1_classifier #(
    parameter int MAX_CLASSES = 64,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input logic clk,
    input logic rst_n,
    st1c_in_if.sink in_ch,
    st1c_out_if.source out_ch,
    st1c_cfg_if.sink cfg
);
    import st1c_pkg::*;

    localparam int AW = $clog2(MAX_CLASSES);
    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);

    typedef enum logic [1:0] {S_LOAD, S_SUM, S_DIV} state_t;

    logic [15:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        assign exp_rom[g] = exp_entry(g);
    end

    logic [LOGIT_W-1:0] mem [MAX_CLASSES];
    logic [LOGIT_W-1:0] rd_data_reg;

    state_t state_reg;
    logic [NCLS_W-1:0] ncls_reg;
    logic [CONF_W-1:0] thr_reg;
    logic [CW-1:0] count_reg, rd_ptr_reg, row_len_reg;
    logic rd_valid_reg;
    logic signed [LOGIT_W-1:0] best_reg;
    logic [AW-1:0] best_idx_reg;
    logic last_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [31:0] rem_reg;
    logic [15:0] quo_reg;
    logic [4:0] div_cnt_reg;
    logic out_valid_reg;
    logic [5:0] out_idx_reg;
    logic [CONF_W-1:0] out_conf_reg;
    logic out_cnf_reg, out_last_reg;

    // row length clamp
    logic [CW-1:0] row_len;
    always_comb
    begin
        if ({1'b0, ncls_reg} < 8'd2) row_len = CW'(2);
        else if (32'(ncls_reg) > MAX_CLASSES) row_len = CW'(MAX_CLASSES);
        else row_len = CW'(ncls_reg);
    end

    logic [CW-1:0] slot;
    assign slot = (32'(count_reg) >= MAX_CLASSES) ? CW'(MAX_CLASSES - 1) : count_reg;
    logic take_new;
    assign take_new = (count_reg == '0) || (in_ch.logit > best_reg);
    logic closes;
    assign closes = (32'(slot) + 1 >= 32'(row_len)) || in_ch.batch_end;

    assign in_ch.ready = (state_reg == S_LOAD) && !(closes && out_valid_reg);
    logic in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;

    // exp lookup of stored word
    logic [16:0] diff;
    logic [15:0] exp_val;
    logic [SUM_W:0] sum_add;
    always_comb
    begin
        diff = 17'($signed({best_reg[15], best_reg}) - $signed({rd_data_reg[15], rd_data_reg}));
        if (32'(diff[16:4]) < EXP_TABLE_DEPTH) exp_val = exp_rom[TW'(diff[16:4])];
        else exp_val = '0;
        sum_add = {1'b0, sum_reg} + (SUM_W+1)'(exp_val);
    end

    logic [32:0] trial;
    assign trial = {rem_reg, 1'b0} - {11'd0, sum_reg};

    // last divide step: quo_reg holds quotient bits 16..1, trial gives bit 0
    logic fire;
    assign fire = (state_reg == S_DIV) && (div_cnt_reg == 5'd17);
    logic [16:0] quo_fin;
    assign quo_fin = {quo_reg, ~trial[32]};
    logic [CONF_W-1:0] conf;
    assign conf = quo_fin[16] ? CONF_W'(65535) : quo_fin[15:0];

    always_ff @(posedge clk)
    begin
        if (in_acc) mem[AW'(slot)] <= in_ch.logit;
        rd_data_reg <= mem[AW'(rd_ptr_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ncls_reg <= NCLS_W'(16);
            thr_reg <= CONF_W'(32768);
            count_reg <= '0;
            rd_ptr_reg <= '0;
            row_len_reg <= '0;
            rd_valid_reg <= 1'b0;
            best_reg <= '0;
            best_idx_reg <= '0;
            last_reg <= 1'b0;
            sum_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            div_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg <= '0;
            out_conf_reg <= '0;
            out_cnf_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_NUM_CLASSES: ncls_reg <= cfg.data[NCLS_W-1:0];
                    CFG_THRESHOLD: thr_reg <= cfg.data;
                    default: ;
                endcase
            end
            // a new word never lands while one is still waiting
            out_valid_reg <= fire || (out_valid_reg && !out_ch.ready);
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (take_new)
                        begin
                            best_reg <= in_ch.logit;
                            best_idx_reg <= AW'(slot);
                        end
                        if (closes)
                        begin
                            state_reg <= S_SUM;
                            row_len_reg <= slot + CW'(1);
                            last_reg <= in_ch.batch_end;
                            count_reg <= '0;
                            rd_ptr_reg <= '0;
                            rd_valid_reg <= 1'b0;
                            sum_reg <= '0;
                        end
                        else
                        begin
                            count_reg <= slot + CW'(1);
                        end
                    end
                end
                S_SUM:
                begin
                    // read pointer runs one ahead of the add
                    if (rd_ptr_reg != row_len_reg) rd_ptr_reg <= rd_ptr_reg + CW'(1);
                    rd_valid_reg <= (rd_ptr_reg != row_len_reg);
                    if (rd_valid_reg)
                    begin
                        sum_reg <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    end
                    if (rd_valid_reg && rd_ptr_reg == row_len_reg)
                    begin
                        state_reg <= S_DIV;
                        rem_reg <= 32'd0;
                        quo_reg <= '0;
                        div_cnt_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    // dividend 2^31: quotient bits 16 down to 0, one per step
                    if (div_cnt_reg == 5'd0)
                    begin
                        // 2^31 >> 17; first step compares 2^15 with the sum
                        rem_reg <= 32'd1 << 14;
                        div_cnt_reg <= 5'd1;
                    end
                    else
                    begin
                        if (!trial[32])
                        begin
                            rem_reg <= trial[31:0];
                            quo_reg <= {quo_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[30:0], 1'b0};
                            quo_reg <= {quo_reg[14:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                        if (fire)
                        begin
                            state_reg <= S_LOAD;
                            best_reg <= '0;
                            best_idx_reg <= '0;
                            out_idx_reg <= 6'(best_idx_reg);
                            out_conf_reg <= conf;
                            out_cnf_reg <= conf >= thr_reg;
                            out_last_reg <= last_reg;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.class_index = out_idx_reg;
    assign out_ch.confidence = out_conf_reg;
    assign out_ch.confident = out_cnf_reg;
    assign out_ch.batch_last = out_last_reg;
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import st1c_pkg::*;

    logic clk;
    logic rst_n;

    st1c_in_if  in_ch ();
    st1c_out_if out_ch ();
    st1c_cfg_if cfg ();

    softmax_top1_classifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // One expected result word.
    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [CONF_W-1:0]  confidence;
        logic               confident;
        logic               batch_last;
    } top1_t;

    // Keeps its own copy of the row, the running best and the registers,
    // and predicts one word per closed row.
    class top1_scoreboard;
        logic [15:0]        exp_lut [256];
        logic [NCLS_W-1:0]  n_classes;
        logic [CONF_W-1:0]  threshold;
        logic signed [15:0] row [64];
        int                 count;
        int                 best_val;
        int                 best_idx;
        top1_t              pending [$];
        int                 errors;

        function new();
            longint unsigned p;
            p = 64'd1 << 32;
            for (int k = 0; k < 256; k++)
            begin
                exp_lut[k] = 16'((p + (64'd1 << 16)) >> 17);
                p = (p * 64'hF07D5F5E + (64'd1 << 31)) >> 32;
            end
            n_classes = 7'd16;
            threshold = 16'd32768;
            count     = 0;
            best_val  = 0;
            best_idx  = 0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == CFG_NUM_CLASSES)
                n_classes = val[NCLS_W-1:0];
            else
                threshold = val;
        endfunction

        function void note_logit(logic signed [15:0] x, logic last);
            int    slot;
            int    len;
            int    d;
            int    k;
            longint sum;
            longint q;
            top1_t r;
            slot = (count >= 64) ? 63 : count;
            row[slot] = x;
            if (count == 0 || int'(x) > best_val)
            begin
                best_val = x;
                best_idx = slot;
            end
            count = slot + 1;
            len = n_classes < 2 ? 2 : (n_classes > 64 ? 64 : n_classes);
            if (count < len && !last)
                return;
            sum = 0;
            for (int i = 0; i < count; i++)
            begin
                d = best_val - int'(row[i]);
                k = d >>> 4;
                if (k < 256)
                    sum += exp_lut[k];
            end
            if (sum > SUM_MAX)
                sum = SUM_MAX;
            q = (64'd1 << 31) / sum;
            if (q > 65535)
                q = 65535;
            r.class_index = best_idx[CLASS_W-1:0];
            r.confidence  = q[15:0];
            r.confident   = (q[15:0] >= threshold);
            r.batch_last  = last;
            pending.push_back(r);
            count    = 0;
            best_val = 0;
            best_idx = 0;
        endfunction

        function void check_word(top1_t got);
            top1_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: idx %0d conf %0d ok %0d last %0d",
                             got.class_index, got.confidence, got.confident,
                             got.batch_last);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp idx %0d conf %0d ok %0d last %0d,",
                             want.class_index, want.confidence, want.confident,
                             want.batch_last,
                             " got idx %0d conf %0d ok %0d last %0d",
                             got.class_index, got.confidence,
                             got.confident, got.batch_last);
            end
        endfunction
    endclass

    top1_scoreboard sb;
    bit  quiet;          // no idling on either side while set
    int  cycles;

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a correct run needs far fewer cycles than this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("** softmax_top1_classifier: FAILED **");
            $finish;
        end
    end

    // Receiver drops ready about 17 percent of the time.
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 17);
    end

    // Monitor: inputs feed the predictor, results get checked.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_logit(in_ch.logit, in_ch.batch_end);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word({out_ch.class_index, out_ch.confidence,
                           out_ch.confident, out_ch.batch_last});
    end

    // Send one logit word; random gaps unless quiet. Valid stays up after
    // the accept so words can follow back to back; drain() drops it.
    task automatic send_logit(input logic signed [15:0] x, input logic last);
        while (!quiet && $urandom_range(99) < 17)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.logit     <= x;
        in_ch.batch_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Let every expected word arrive, then give a partly loaded row or a
    // late walk-and-divide time to settle before touching the registers.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_phase(input logic [15:0] n, input logic [15:0] thr);
        drain();
        write_reg(CFG_NUM_CLASSES, n);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // Logits around a random base with a random spread, so confidence
    // covers the whole range from near uniform to a clear winner.
    function automatic logic signed [15:0] pick_logit(int base, int spread);
        int v;
        v = base + $urandom_range(2 * spread) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    int spreads [5] = '{0, 16, 256, 4096, 65535};
    logic [15:0] n_set [6] = '{16'd127, 16'd0, 16'd1, 16'd7, 16'd64, 16'd16};

    initial
    begin
        int sent;
        int len;
        int base;
        int spread;
        sb     = new();
        quiet  = 1'b0;
        cycles = 0;
        rst_n  = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.logit     = '0;
        in_ch.batch_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_NUM_CLASSES;
        cfg.data  = '0;
        out_ch.ready = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values first: one row of 16 with a clear winner.
        for (int i = 0; i < 16; i++)
            send_logit(i == 9 ? 16'sd2560 : -16'sd256, 1'b0);

        // Two-class rows, threshold 0: extremes, ties, equal minimum.
        set_phase(16'd2, 16'd0);
        send_logit(16'sh7FFF, 1'b0);
        send_logit(16'sh8000, 1'b0);
        send_logit(16'sh8000, 1'b0);
        send_logit(16'sh7FFF, 1'b0);
        send_logit(16'sd5, 1'b0);
        send_logit(16'sd5, 1'b0);
        send_logit(16'sh8000, 1'b0);
        send_logit(16'sh8000, 1'b1);

        // Threshold at maximum: flat row, then a batch end that closes early.
        set_phase(16'd4, 16'd65535);
        for (int i = 0; i < 4; i++)
            send_logit(16'sd0, 1'b0);
        send_logit(-16'sd100, 1'b0);
        send_logit(16'sd100, 1'b1);

        // Count lowered mid-row: the next logit closes the row.
        set_phase(16'd8, 16'd32768);
        for (int i = 0; i < 3; i++)
            send_logit(pick_logit(0, 64), 1'b0);
        drain();
        write_reg(CFG_NUM_CLASSES, 16'd2);
        send_logit(16'sd300, 1'b0);

        // Random phases: mostly whole rows, some batch ends mid-row.
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 3)
                0: set_phase(n_set[ph], 16'($urandom));
                1: set_phase(n_set[ph], ph == 1 ? 16'd0 : 16'd65535);
                default: set_phase(n_set[ph], 16'($urandom_range(4096, 40000)));
            endcase
            len = n_set[ph] < 2 ? 2 : (n_set[ph] > 64 ? 64 : n_set[ph]);
            for (int k = 0; k < 205; )
            begin
                base   = $urandom_range(65535) - 32768;
                spread = spreads[$urandom_range(4)];
                for (int i = 0; i < len && k < 205; i++)
                begin
                    quiet = (sent >= 500 && sent < 700);
                    send_logit(pick_logit(base, spread),
                               $urandom_range(99) < (i == len - 1 ? 12 : 2));
                    k++;
                    sent++;
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** softmax_top1_classifier: PASSED **");
        else
            $display("** softmax_top1_classifier: FAILED **");
        $finish;
    end
endmodule

// File: files.f
src/st1c_pkg.sv
src/st1c_if.sv
src/softmax_top1_classifier.sv
test/tb.sv
